[rtl/rtnh_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the ray/triangle nearest-hit block.
// No dependencies; every other file imports this package.
package rtnh_pkg;

    localparam int COORD_BITS = 16;
    localparam int ID_BITS    = 16;
    localparam int T_BITS     = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int CROSS_W    = 2 * DIFF_W + 1;
    localparam int PROD_W     = CROSS_W + DIFF_W;
    localparam int DOT_W      = PROD_W + 4;
    localparam int FRAC_BITS  = 16;
    localparam int QDEPTH     = 8;
    localparam int QADDR_W    = $clog2(QDEPTH);
    localparam int STAGES     = 5;
    localparam int CNT_W      = $clog2(T_BITS);

    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [2:0] REG_DIRECTION_X = 3'd3;
    localparam logic [2:0] REG_DIRECTION_Y = 3'd4;
    localparam logic [2:0] REG_DIRECTION_Z = 3'd5;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] first_z;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic signed [COORD_BITS-1:0] second_z;
        logic signed [COORD_BITS-1:0] third_x;
        logic signed [COORD_BITS-1:0] third_y;
        logic signed [COORD_BITS-1:0] third_z;
        logic [ID_BITS-1:0]           triangle_id;
        logic                         last_in_batch;
    } in_t;

    typedef struct packed {
        logic               any_hit;
        logic [T_BITS-1:0]  nearest_t;
        logic [ID_BITS-1:0] nearest_id;
    } out_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] origin_z;
        logic signed [COORD_BITS-1:0] direction_x;
        logic signed [COORD_BITS-1:0] direction_y;
        logic signed [COORD_BITS-1:0] direction_z;
    } ray_t;

    // One classified triangle: magnitudes of numerator and denominator.
    typedef struct packed {
        logic               hit;
        logic               last;
        logic [ID_BITS-1:0] id;
        logic [DOT_W-1:0]   num;
        logic [DOT_W-1:0]   den;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE
    } back_state_t;

endpackage

[rtl/rtnh_front.sv]
`timescale 1ns / 1ps
// Front end: five-stage pipeline computing plane and edge tests per triangle.
// Depends on rtnh_pkg.
module rtnh_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  rtnh_pkg::in_t   tri_in,
    input  rtnh_pkg::ray_t  ray,
    output logic            push,
    output rtnh_pkg::entry_t entry,
    output logic [$clog2(rtnh_pkg::STAGES+1)-1:0] inflight
);
    import rtnh_pkg::*;

    logic [STAGES-1:0] v_reg;

    // stage 1
    logic signed [DIFF_W-1:0] e1_reg [3];
    logic signed [DIFF_W-1:0] e2_reg [3];
    logic signed [DIFF_W-1:0] a_reg  [3][3];
    // stage 2
    logic signed [2*DIFF_W-1:0] np_reg [3][2];
    logic signed [2*DIFF_W-1:0] cp_reg [3][3][2];
    logic signed [DIFF_W-1:0]   rel2_reg [3];
    // stage 3
    logic signed [CROSS_W-1:0] n_reg  [3];
    logic signed [CROSS_W-1:0] cr_reg [3][3];
    logic signed [DIFF_W-1:0]  rel3_reg [3];
    // stage 4
    logic signed [PROD_W-1:0] dp_reg [3];
    logic signed [PROD_W-1:0] up_reg [3];
    logic signed [PROD_W-1:0] sp_reg [3][3];
    // stage 5
    logic signed [DOT_W-1:0] den_reg;
    logic signed [DOT_W-1:0] num_reg;
    logic signed [DOT_W-1:0] s_reg [3];

    logic [ID_BITS-1:0] id_reg   [STAGES];
    logic               last_reg [STAGES];

    logic signed [COORD_BITS-1:0] p [3][3];
    logic signed [COORD_BITS-1:0] o [3];
    logic signed [COORD_BITS-1:0] d [3];

    always_comb
    begin
        p[0][0] = tri_in.first_x;  p[0][1] = tri_in.first_y;  p[0][2] = tri_in.first_z;
        p[1][0] = tri_in.second_x; p[1][1] = tri_in.second_y; p[1][2] = tri_in.second_z;
        p[2][0] = tri_in.third_x;  p[2][1] = tri_in.third_y;  p[2][2] = tri_in.third_z;
        o[0] = ray.origin_x;    o[1] = ray.origin_y;    o[2] = ray.origin_z;
        d[0] = ray.direction_x; d[1] = ray.direction_y; d[2] = ray.direction_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[STAGES-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg[0]   <= tri_in.triangle_id;
        last_reg[0] <= tri_in.last_in_batch;
        for (int s = 1; s < STAGES; s++)
        begin
            id_reg[s]   <= id_reg[s-1];
            last_reg[s] <= last_reg[s-1];
        end
        for (int c = 0; c < 3; c++)
        begin
            e1_reg[c] <= DIFF_W'(p[1][c]) - DIFF_W'(p[0][c]);
            e2_reg[c] <= DIFF_W'(p[2][c]) - DIFF_W'(p[1][c]);
            for (int k = 0; k < 3; k++)
            begin
                a_reg[k][c] <= DIFF_W'(p[k][c]) - DIFF_W'(o[c]);
            end
        end
        // stage 2: cross-product partial products
        for (int c = 0; c < 3; c++)
        begin
            np_reg[c][0] <= e1_reg[(c+1)%3] * e2_reg[(c+2)%3];
            np_reg[c][1] <= e1_reg[(c+2)%3] * e2_reg[(c+1)%3];
            rel2_reg[c]  <= a_reg[0][c];
            for (int k = 0; k < 3; k++)
            begin
                cp_reg[k][c][0] <= a_reg[k][(c+1)%3] * a_reg[(k+1)%3][(c+2)%3];
                cp_reg[k][c][1] <= a_reg[k][(c+2)%3] * a_reg[(k+1)%3][(c+1)%3];
            end
        end
        // stage 3: finish cross products
        for (int c = 0; c < 3; c++)
        begin
            n_reg[c]    <= CROSS_W'(np_reg[c][0]) - CROSS_W'(np_reg[c][1]);
            rel3_reg[c] <= rel2_reg[c];
            for (int k = 0; k < 3; k++)
            begin
                cr_reg[k][c] <= CROSS_W'(cp_reg[k][c][0]) - CROSS_W'(cp_reg[k][c][1]);
            end
        end
        // stage 4: dot-product terms
        for (int c = 0; c < 3; c++)
        begin
            dp_reg[c] <= PROD_W'(n_reg[c]) * PROD_W'(d[c]);
            up_reg[c] <= PROD_W'(n_reg[c]) * PROD_W'(rel3_reg[c]);
            for (int k = 0; k < 3; k++)
            begin
                sp_reg[k][c] <= PROD_W'(cr_reg[k][c]) * PROD_W'(d[c]);
            end
        end
        // stage 5: sum terms
        den_reg <= DOT_W'(dp_reg[0]) + DOT_W'(dp_reg[1]) + DOT_W'(dp_reg[2]);
        num_reg <= DOT_W'(up_reg[0]) + DOT_W'(up_reg[1]) + DOT_W'(up_reg[2]);
        for (int k = 0; k < 3; k++)
        begin
            s_reg[k] <= DOT_W'(sp_reg[k][0]) + DOT_W'(sp_reg[k][1]) + DOT_W'(sp_reg[k][2]);
        end
    end

    // Classify: plane test, then all edge signs strictly equal.
    logic den_neg;
    logic plane_ok;
    logic all_pos;
    logic all_neg;

    always_comb
    begin
        den_neg  = den_reg[DOT_W-1];
        plane_ok = (den_reg != '0) && ((num_reg == '0) || (num_reg[DOT_W-1] == den_neg));
        all_pos  = 1'b1;
        all_neg  = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            all_pos = all_pos && !s_reg[k][DOT_W-1] && (s_reg[k] != '0);
            all_neg = all_neg && s_reg[k][DOT_W-1];
        end
        entry.hit  = plane_ok && (all_pos || all_neg);
        entry.last = last_reg[STAGES-1];
        entry.id   = id_reg[STAGES-1];
        entry.num  = den_neg ? DOT_W'(-num_reg) : DOT_W'(num_reg);
        entry.den  = den_neg ? DOT_W'(-den_reg) : DOT_W'(den_reg);
        push       = v_reg[STAGES-1];
        inflight   = $bits(inflight)'($countones(v_reg));
    end

endmodule

[rtl/rtnh_queue.sv]
`timescale 1ns / 1ps
// Small FIFO between the front pipeline and the divider back end.
// Depends on rtnh_pkg.
module rtnh_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rtnh_pkg::entry_t push_data,
    input  logic             pop,
    output logic             not_empty,
    output rtnh_pkg::entry_t head,
    output logic [rtnh_pkg::QADDR_W:0] count
);
    import rtnh_pkg::*;

    entry_t mem [QDEPTH];
    entry_t head_reg;
    logic [QADDR_W-1:0] wr_reg;
    logic [QADDR_W-1:0] rd_reg;
    logic [QADDR_W-1:0] rd_next;
    logic [QADDR_W:0]   cnt_reg;

    assign rd_next = rd_reg + QADDR_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_reg + (QADDR_W+1)'(push) - (QADDR_W+1)'(pop);
        end
    end

    // Prefetch the next head; forward a beat written into an empty queue.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
        if (push && (wr_reg == rd_next))
            head_reg <= push_data;
        else
            head_reg <= mem[rd_next];
    end

    assign head      = head_reg;
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

endmodule

[rtl/rtnh_back.sv]
`timescale 1ns / 1ps
// Back end: bit-serial Q16.16 divider, nearest-hit tracking, result register.
// Depends on rtnh_pkg.
module rtnh_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  rtnh_pkg::entry_t q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output rtnh_pkg::out_t   out_data
);
    import rtnh_pkg::*;

    back_state_t state_reg, state_next;
    entry_t      ent_reg, ent_next;
    logic [DOT_W:0]     rem_reg, rem_next;
    logic [T_BITS-1:0]  tail_reg, tail_next;
    logic [T_BITS-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [T_BITS-1:0]  best_t_reg, best_t_next;
    logic [ID_BITS-1:0] best_id_reg, best_id_next;
    logic               best_v_reg, best_v_next;
    logic               ov_reg, ov_next;
    out_t               od_reg, od_next;

    logic [DOT_W:0]         shifted;
    logic                   fits;
    logic                   win;
    logic                   out_free;
    logic [T_BITS-1:0]      nb_t;
    logic [ID_BITS-1:0]     nb_id;
    logic                   nb_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            best_t_reg  <= '1;
            best_id_reg <= '0;
            best_v_reg  <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            best_t_reg  <= best_t_next;
            best_id_reg <= best_id_next;
            best_v_reg  <= best_v_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        rem_reg  <= rem_next;
        tail_reg <= tail_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        od_reg   <= od_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        ent_next     = ent_reg;
        rem_next     = rem_reg;
        tail_next    = tail_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        best_t_next  = best_t_reg;
        best_id_next = best_id_reg;
        best_v_next  = best_v_reg;
        od_next      = od_reg;
        q_pop        = 1'b0;
        out_free     = !ov_reg || !out_stall;
        ov_next      = ov_reg && out_stall;

        shifted = {rem_reg[DOT_W-1:0], tail_reg[T_BITS-1]};
        fits    = (shifted >= {1'b0, ent_reg.den});

        win   = ent_reg.hit && (!best_v_reg || (quo_reg < best_t_reg));
        nb_t  = win ? quo_reg : best_t_reg;
        nb_id = win ? ent_reg.id : best_id_reg;
        nb_v  = best_v_reg || ent_reg.hit;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    ent_next = q_head;
                    cnt_next = '0;
                    quo_next = '1;
                    // quotient overflows 32 bits exactly when num >= den * 2^16
                    if (q_head.hit && ({FRAC_BITS'(0), q_head.num} < {q_head.den, FRAC_BITS'(0)}))
                    begin
                        rem_next   = (DOT_W+1)'(q_head.num >> FRAC_BITS);
                        tail_next  = {q_head.num[FRAC_BITS-1:0], (T_BITS-FRAC_BITS)'(0)};
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = fits ? (shifted - {1'b0, ent_reg.den}) : shifted;
                tail_next = {tail_reg[T_BITS-2:0], 1'b0};
                quo_next  = {quo_reg[T_BITS-2:0], fits};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(T_BITS - 1))
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!ent_reg.last)
                begin
                    best_t_next  = nb_t;
                    best_id_next = nb_id;
                    best_v_next  = nb_v;
                    state_next   = ST_IDLE;
                end
                else if (out_free)
                begin
                    ov_next            = 1'b1;
                    od_next.any_hit    = nb_v;
                    od_next.nearest_t  = nb_t;
                    od_next.nearest_id = nb_id;
                    best_t_next        = '1;
                    best_id_next       = '0;
                    best_v_next        = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

[rtl/ray_triangle_nearest_hit.sv]
`timescale 1ns / 1ps
// Top level of the nearest ray/triangle hit block: ray registers, front
// pipeline, queue and divider back end. Depends on rtnh_pkg and rtnh_* modules.
//
//   channel   | handshake          | beat
//   ----------+--------------------+--------------------------------------
//   input     | in_valid/in_stall  | in_t: three vertices, id, last flag
//   output    | out_valid/out_stall| out_t: any_hit, nearest_t, nearest_id
//   config    | cfg_we             | cfg_index selects, cfg_data is value
//
// Flow: a triangle passes through the front pipeline; the back end then sends a
// miss or a saturated t straight to its update state, and runs a hit through
// the 32-step restoring divider that yields one quotient bit a cycle.
// Reset clears the ray registers, the running best hit and all valid state.
// in_stall rises while the queue plus items in flight reach 8 entries; a
// stalled output holds the result and the back end waits on the next last beat.
module ray_triangle_nearest_hit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  rtnh_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output rtnh_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [rtnh_pkg::COORD_BITS-1:0] cfg_data
);
    import rtnh_pkg::*;

    ray_t ray_reg;

    logic   accept;
    logic   push;
    entry_t push_data;
    logic   q_pop;
    logic   q_valid;
    entry_t q_head;
    logic [QADDR_W:0] q_count;
    logic [$clog2(STAGES+1)-1:0] inflight;
    logic [QADDR_W+2:0] used;

    // Hold the ray; unknown indexes drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:    ray_reg.origin_x    <= cfg_data;
                REG_ORIGIN_Y:    ray_reg.origin_y    <= cfg_data;
                REG_ORIGIN_Z:    ray_reg.origin_z    <= cfg_data;
                REG_DIRECTION_X: ray_reg.direction_x <= cfg_data;
                REG_DIRECTION_Y: ray_reg.direction_y <= cfg_data;
                REG_DIRECTION_Z: ray_reg.direction_z <= cfg_data;
                default:         ray_reg             <= ray_reg;
            endcase
        end
    end

    // Reserve a queue slot for every beat still in the pipeline.
    assign used     = (QADDR_W+3)'(q_count) + (QADDR_W+3)'(inflight);
    assign in_stall = (used >= (QADDR_W+3)'(QDEPTH));
    assign accept   = in_valid && !in_stall;

    rtnh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .tri_in   (in_data),
        .ray      (ray_reg),
        .push     (push),
        .entry    (push_data),
        .inflight (inflight)
    );

    rtnh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head),
        .count     (q_count)
    );

    rtnh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
